FILE: hw/rtl/gfcv_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and byte-step functions for the GNSS frame checksum validator.
// No dependencies; imported by gfcv_frame_tracker and the core top level.
package gfcv_pkg;

   localparam int unsigned DEF_MAX_FRAME_BYTES = 4096;

   localparam logic [7:0]  CH_DOLLAR   = 8'h24;
   localparam logic [7:0]  CH_HASH     = 8'h23;
   localparam logic [7:0]  CH_STAR     = 8'h2A;
   localparam logic [31:0] CRC32_POLY  = 32'hEDB88320;
   localparam logic [3:0]  DIGITS_NMEA = 4'd2;
   localparam logic [3:0]  DIGITS_HASH = 4'd8;
   localparam logic [11:0] BODY_SAT    = 12'hFFF;
   localparam int unsigned RSP_DATA_W  = 48;

   typedef enum logic [1:0] {
      ST_GOOD     = 2'd0,
      ST_BAD      = 2'd1,
      ST_STRUCT   = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic {
      FT_NMEA = 1'b0,
      FT_HASH = 1'b1
   } frame_kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_NMEA = 3'b010,
      MODE_HASH = 3'b100
   } frame_mode_type;

   typedef struct packed {
      logic           valid;
      status_type     status;
      frame_kind_type frame_type;
      logic [11:0]    body_bytes;
      logic [31:0]    computed_check;
   } result_type;

   // Reflected CRC-32 over one byte, bit by bit.
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'b0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Nibble value of an ASCII hex digit; bit 4 set marks a non-hex byte.
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] v;
      case (b) inside
         [8'h30:8'h39]: v = 5'(b - 8'h30);
         [8'h61:8'h66]: v = 5'(b - 8'h61 + 8'd10);
         [8'h41:8'h46]: v = 5'(b - 8'h41 + 8'd10);
         default:       v = 5'h10;
      endcase
      return v;
   endfunction

endpackage

FILE: hw/rtl/gfcv_frame_tracker.sv
`timescale 1ns / 1ps
// Frame state, running XOR / CRC-32 and hex digit collection, one byte per step.
// Depends on gfcv_pkg.
module gfcv_frame_tracker #(
   parameter int unsigned MAX_FRAME_BYTES = gfcv_pkg::DEF_MAX_FRAME_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [7:0]           rx_byte,
   output gfcv_pkg::result_type result
);
   import gfcv_pkg::*;

   localparam int unsigned CountW = $clog2(MAX_FRAME_BYTES + 1);

   frame_mode_type    mode_ff, mode_in;
   logic [CountW-1:0] byte_count_ff, byte_count_in;
   logic [CountW-1:0] body_count_ff, body_count_in;
   logic [3:0]        digit_count_ff, digit_count_in;
   logic [7:0]        xor_acc_ff, xor_acc_in;
   logic [31:0]       crc_acc_ff, crc_acc_in;
   logic [31:0]       hex_acc_ff, hex_acc_in;

   logic        is_start;
   logic        emit;
   logic [4:0]  nib;
   logic [31:0] hex_shift;
   logic [31:0] check_cur;
   logic [3:0]  need;
   status_type  status;

   assign is_start  = (rx_byte == CH_DOLLAR) || (rx_byte == CH_HASH);
   assign nib       = hex_value(rx_byte);
   assign hex_shift = {hex_acc_ff[27:0], nib[3:0]};
   assign check_cur = (mode_ff == MODE_HASH) ? crc_acc_ff : {24'b0, xor_acc_ff};
   assign need      = (mode_ff == MODE_NMEA) ? DIGITS_NMEA : DIGITS_HASH;

   always_comb begin
      mode_in        = mode_ff;
      byte_count_in  = byte_count_ff;
      body_count_in  = body_count_ff;
      digit_count_in = digit_count_ff;
      xor_acc_in     = xor_acc_ff;
      crc_acc_in     = crc_acc_ff;
      hex_acc_in     = hex_acc_ff;
      emit           = 1'b0;
      status         = ST_GOOD;

      if (mode_ff == MODE_IDLE || (is_start && digit_count_ff == 4'd0)) begin
         // open a new frame, dropping any frame still before its asterisk
         if (is_start) begin
            mode_in        = (rx_byte == CH_DOLLAR) ? MODE_NMEA : MODE_HASH;
            byte_count_in  = CountW'(1);
            body_count_in  = '0;
            digit_count_in = 4'd0;
            xor_acc_in     = 8'd0;
            crc_acc_in     = 32'd0;
            hex_acc_in     = 32'd0;
         end
      end else if (32'(byte_count_ff) >= 32'(MAX_FRAME_BYTES)) begin
         emit   = 1'b1;
         status = ST_OVERFLOW;
      end else begin
         byte_count_in = byte_count_ff + CountW'(1);
         if (digit_count_ff == 4'd0) begin
            if (rx_byte == CH_STAR) begin
               digit_count_in = 4'd1;
            end else begin
               xor_acc_in    = xor_acc_ff ^ rx_byte;
               crc_acc_in    = crc32_byte(crc_acc_ff, rx_byte);
               body_count_in = body_count_ff + CountW'(1);
            end
         end else if (nib[4]) begin
            emit   = 1'b1;
            status = ST_STRUCT;
         end else begin
            hex_acc_in = hex_shift;
            if (digit_count_ff < need) begin
               digit_count_in = digit_count_ff + 4'd1;
            end else begin
               emit   = 1'b1;
               status = (hex_shift == check_cur) ? ST_GOOD : ST_BAD;
            end
         end
      end

      if (emit) begin
         mode_in        = MODE_IDLE;
         byte_count_in  = '0;
         body_count_in  = '0;
         digit_count_in = 4'd0;
         xor_acc_in     = 8'd0;
         crc_acc_in     = 32'd0;
         hex_acc_in     = 32'd0;
      end
   end

   always_comb begin
      result.valid          = step_en && emit;
      result.status         = status;
      result.frame_type     = (mode_ff == MODE_HASH) ? FT_HASH : FT_NMEA;
      result.body_bytes     = (32'(body_count_ff) > 32'(BODY_SAT)) ? BODY_SAT
                                                                   : 12'(body_count_ff);
      result.computed_check = check_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         byte_count_ff  <= '0;
         body_count_ff  <= '0;
         digit_count_ff <= 4'd0;
         xor_acc_ff     <= 8'd0;
         crc_acc_ff     <= 32'd0;
         hex_acc_ff     <= 32'd0;
      end else if (step_en) begin
         mode_ff        <= mode_in;
         byte_count_ff  <= byte_count_in;
         body_count_ff  <= body_count_in;
         digit_count_ff <= digit_count_in;
         xor_acc_ff     <= xor_acc_in;
         crc_acc_ff     <= crc_acc_in;
         hex_acc_ff     <= hex_acc_in;
      end
   end

   a_digit_bound: assert property (@(posedge clock) disable iff (reset)
      digit_count_ff <= DIGITS_HASH)
      else $error("digit count past eight");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE) |-> (byte_count_ff == '0 && digit_count_ff == 4'd0))
      else $error("idle with frame counters set");

endmodule

FILE: hw/rtl/gnss_frame_checksum_validator_core.sv
`timescale 1ns / 1ps
// Top level of the GNSS frame checksum validator: input byte register, frame tracker,
// result register. Depends on gfcv_pkg and gfcv_frame_tracker.
//
// Usage
//   req_*  : one received UART byte per transfer. Outside a frame every byte other
//            than '$' (NMEA, two hex digit XOR) or '#' (reflected CRC-32, eight
//            hex digits) is dropped.
//   rsp_*  : zero or one result per byte: good / bad checksum, bad structure
//            (non-hex byte after '*') or overflow (frame longer than
//            MAX_FRAME_BYTES). frame_type travels on rsp_tuser.
//   Order: an accepted byte is processed once the result register is free or
//            draining; a result it causes is registered and shown on rsp_tvalid.
//   Throughput: one byte per cycle unless a result waits on rsp_tready; the
//            byte step (unrolled CRC-32, hex compare) between registers is combinational.
//   Stall: while a result waits on rsp_tready the input register still takes one
//            byte; req_tready drops only when both registers are full.
//   Reset: synchronous, active high; clears both valid flags and returns the
//            tracker to idle with every accumulator zero.
module gnss_frame_checksum_validator_core #(
   parameter int unsigned MAX_FRAME_BYTES = gfcv_pkg::DEF_MAX_FRAME_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] rx_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] status, [13:2] body_bytes, [45:14] computed_check, [47:46] zero
   output logic [gfcv_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser   // [0] frame_type
);
   import gfcv_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type result;
   logic       advance;
   logic       req_take;

   // Process the held byte whenever the result register is free or draining.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = result.valid || (out_valid_ff && !rsp_tready);

   gfcv_frame_tracker #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_tracker (
      .clock  (clock),
      .reset  (reset),
      .step_en(advance),
      .rx_byte(in_byte_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on transfer only, no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
      end
      if (result.valid) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff.computed_check, out_ff.body_bytes, out_ff.status};
   assign rsp_tuser  = out_ff.frame_type;

   a_ready_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff))
      else $error("input held off with a free stage");

   a_input_drains: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_tready) |=> (!in_valid_ff || $past(req_tvalid)))
      else $error("held byte not processed while output drains");

   a_nmea_check_narrow: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == FT_NMEA) |-> (rsp_tdata[45:22] == 24'd0))
      else $error("NMEA check wider than eight bits");

endmodule
